// ----- src/dss_pkg.sv -----
// Shared types and constants for the deadline slot scheduler.
`timescale 1ns / 1ps
`default_nettype none
package dss_pkg;

	localparam int DSS_SLOTS    = 64;
	localparam int DSS_IDX_W    = 6;
	localparam int DSS_JOB_W    = 16;
	localparam int DSS_PROFIT_W = 24;
	localparam int DSS_DL_W     = 7;
	localparam int DSS_SUM_W    = 30;

	localparam logic OP_SCHED = 1'b0;
	localparam logic OP_READ  = 1'b1;

	localparam logic KIND_VERDICT = 1'b0;
	localparam logic KIND_ENTRY   = 1'b1;

	// outcome of one bitmap search
	typedef struct packed {
		logic                 found;
		logic [DSS_IDX_W-1:0] idx;
	} dss_hit_t;

endpackage
`default_nettype wire

// ----- src/deadline_slot_scheduler_core.sv -----
// Top level of the deadline slot scheduler: slot map, profit total, readout sequencer.
// Schedule word: verdict is in the output register the cycle after accept; one job per
//   cycle while the output is taken (one priority encode over the slot map).
// Readout word: per filled slot an owner memory read, then an output load that waits
//   while the output is held; an empty map loads its single answer at accept.
// Reset clears the slot map, the profit total and all control; owner memory is not reset.
`timescale 1ns / 1ps
`default_nettype none
module deadline_slot_scheduler_core #(
	parameter int SLOTS = dss_pkg::DSS_SLOTS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic                             op,
	input  wire logic [dss_pkg::DSS_JOB_W-1:0]    job_id,
	input  wire logic [dss_pkg::DSS_PROFIT_W-1:0] profit,
	input  wire logic [dss_pkg::DSS_DL_W-1:0]     deadline,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic                                  kind,
	output logic                                  placed,
	output logic [dss_pkg::DSS_IDX_W-1:0]         slot_index,
	output logic [dss_pkg::DSS_JOB_W-1:0]         slot_job,
	output logic [dss_pkg::DSS_SUM_W-1:0]         total_profit,
	output logic                                  last
);
	import dss_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	localparam logic [1:0] ST_IDLE     = 2'd0;
	localparam logic [1:0] ST_RD_ISSUE = 2'd1;
	localparam logic [1:0] ST_RD_WAIT  = 2'd2;

	logic [1:0]           state_q;
	logic [SLOTS-1:0]     taken_q;
	logic [DSS_SUM_W-1:0] sum_q;
	logic [IW-1:0]        rd_idx_q;
	logic                 rd_last_q;

	logic [DSS_DL_W-1:0]  lim;
	dss_hit_t             free_hit;
	dss_hit_t             low_hit;
	logic [DSS_SUM_W:0]   sum_wide;
	logic [DSS_SUM_W-1:0] sum_next;
	logic                 out_free;
	logic                 out_load;
	logic                 in_acc;
	logic                 mem_we;
	logic                 mem_re;
	logic [DSS_JOB_W-1:0] mem_rdata;
	logic [SLOTS-1:0]     low_bit;

	assign lim = (deadline > DSS_DL_W'(SLOTS)) ? DSS_DL_W'(SLOTS) : deadline;

	dss_slot_search #(
		.SLOTS(SLOTS)
	) u_search (
		.taken   (taken_q),
		.lim     (lim),
		.free_hit(free_hit),
		.low_hit (low_hit)
	);

	assign sum_wide = {1'b0, sum_q} + (DSS_SUM_W + 1)'(profit);
	assign sum_next = sum_wide[DSS_SUM_W] ? '1 : sum_wide[DSS_SUM_W-1:0];

	assign out_free = !out_valid || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || !out_free;
	assign in_acc   = in_valid && !in_stall;

	// a new word enters the output register this cycle
	assign out_load = (in_acc && ((op == OP_SCHED) || (taken_q == '0)))
		|| ((state_q == ST_RD_WAIT) && out_free);

	assign mem_we  = in_acc && (op == OP_SCHED) && free_hit.found;
	assign mem_re  = (state_q == ST_RD_ISSUE);
	assign low_bit = SLOTS'(1) << low_hit.idx[IW-1:0];

	dss_owner_ram #(
		.DEPTH(SLOTS),
		.AW   (IW),
		.DW   (DSS_JOB_W)
	) u_owner (
		.clk  (clk),
		.we   (mem_we),
		.waddr(free_hit.idx[IW-1:0]),
		.wdata(job_id),
		.re   (mem_re),
		.raddr(low_hit.idx[IW-1:0]),
		.rdata(mem_rdata)
	);

	// control and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			taken_q   <= '0;
			sum_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (op == OP_SCHED) begin
							if (free_hit.found) begin
								taken_q[free_hit.idx[IW-1:0]] <= 1'b1;
								sum_q <= sum_next;
							end
						end else if (taken_q == '0) begin
							sum_q <= '0;
						end else begin
							state_q <= ST_RD_ISSUE;
						end
					end
				end
				ST_RD_ISSUE: begin
					// drop the slot from the map as it is read out
					taken_q <= taken_q & ~low_bit;
					state_q <= ST_RD_WAIT;
				end
				ST_RD_WAIT: begin
					if (out_free) begin
						if (rd_last_q) begin
							sum_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_RD_ISSUE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// readout slot tracking
	always_ff @(posedge clk) begin
		if (state_q == ST_RD_ISSUE) begin
			rd_idx_q  <= low_hit.idx[IW-1:0];
			rd_last_q <= (taken_q & ~low_bit) == '0;
		end
	end

	// output word
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc) begin
			last <= 1'b1;
			if (op == OP_SCHED) begin
				kind         <= KIND_VERDICT;
				placed       <= free_hit.found;
				slot_index   <= free_hit.found ? free_hit.idx : '0;
				slot_job     <= job_id;
				total_profit <= free_hit.found ? sum_next : sum_q;
			end else begin
				kind         <= KIND_ENTRY;
				placed       <= 1'b0;
				slot_index   <= '0;
				slot_job     <= '0;
				total_profit <= sum_q;
			end
		end else if (state_q == ST_RD_WAIT && out_free) begin
			kind         <= KIND_ENTRY;
			placed       <= 1'b1;
			slot_index   <= DSS_IDX_W'(rd_idx_q);
			slot_job     <= mem_rdata;
			total_profit <= sum_q;
			last         <= rd_last_q;
		end
	end

endmodule
`default_nettype wire

// ----- src/dss_owner_ram.sv -----
// Slot owner memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module dss_owner_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int DW    = 16
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- src/dss_slot_search.sv -----
// Bitmap searches: latest free slot below a limit, earliest filled slot.
`timescale 1ns / 1ps
`default_nettype none
module dss_slot_search #(
	parameter int SLOTS = 64
) (
	input  wire logic [SLOTS-1:0]          taken,
	input  wire logic [dss_pkg::DSS_DL_W-1:0] lim,
	output dss_pkg::dss_hit_t              free_hit,
	output dss_pkg::dss_hit_t              low_hit
);
	import dss_pkg::*;

	logic [SLOTS-1:0] free_mask;

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			free_mask[i] = !taken[i] && (DSS_DL_W'(i) < lim);
		end
	end

	// highest free bit wins
	always_comb begin
		free_hit = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (free_mask[i]) begin
				free_hit.found = 1'b1;
				free_hit.idx   = DSS_IDX_W'(i);
			end
		end
	end

	// lowest filled bit wins
	always_comb begin
		low_hit = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (taken[i]) begin
				low_hit.found = 1'b1;
				low_hit.idx   = DSS_IDX_W'(i);
			end
		end
	end

endmodule
`default_nettype wire

// ----- bench/dss_checker.sv -----
// Checker for the deadline slot scheduler: predicts every result word and compares.
`timescale 1ns / 1ps
module dss_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  logic                             op,
	input  logic [dss_pkg::DSS_JOB_W-1:0]    job_id,
	input  logic [dss_pkg::DSS_PROFIT_W-1:0] profit,
	input  logic [dss_pkg::DSS_DL_W-1:0]     deadline,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  logic                             kind,
	input  logic                             placed,
	input  logic [dss_pkg::DSS_IDX_W-1:0]    slot_index,
	input  logic [dss_pkg::DSS_JOB_W-1:0]    slot_job,
	input  logic [dss_pkg::DSS_SUM_W-1:0]    total_profit,
	input  logic                             last,
	output int                               errors,
	output int                               pending
);
	import dss_pkg::*;

	localparam logic [DSS_SUM_W-1:0] SUM_CEIL = '1;

	typedef struct packed {
		logic                 kind;
		logic                 placed;
		logic [DSS_IDX_W-1:0] idx;
		logic [DSS_JOB_W-1:0] job;
		logic [DSS_SUM_W-1:0] total;
		logic                 last;
	} slot_word_t;

	// mirror of the block's schedule state
	logic [DSS_SLOTS-1:0] map_taken;
	logic [DSS_JOB_W-1:0] map_owner [DSS_SLOTS];
	logic [DSS_SUM_W-1:0] sum_profit;
	int                   latest_dl;

	slot_word_t due_words [$];
	slot_word_t want;

	initial begin
		errors  = 0;
		pending = 0;
	end

	task automatic report_mismatch(input string msg);
		if (errors < 30)
			$display("%0t dss_checker: %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] exp_val);
		if (got !== exp_val)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, exp_val));
	endtask

	// apply one accepted input word to the mirror and queue the words it owes
	task automatic place_or_dump(input logic o, input logic [DSS_JOB_W-1:0] j,
			input logic [DSS_PROFIT_W-1:0] p, input logic [DSS_DL_W-1:0] d);
		int lim;
		int s;
		int where;
		int nfill;
		int k;
		bit got;
		logic [DSS_SUM_W:0] acc;
		slot_word_t w;
		if (o == OP_SCHED) begin
			lim = (d > DSS_SLOTS) ? DSS_SLOTS : int'(d);
			if (lim > latest_dl)
				latest_dl = lim;
			got   = 0;
			where = 0;
			// latest free slot below the deadline
			for (s = lim; s > 0 && !got; s--) begin
				if (!map_taken[s-1]) begin
					got   = 1;
					where = s - 1;
				end
			end
			if (got) begin
				map_taken[where] = 1'b1;
				map_owner[where] = j;
				acc = {1'b0, sum_profit} + (DSS_SUM_W + 1)'(p);
				sum_profit = acc[DSS_SUM_W] ? SUM_CEIL : acc[DSS_SUM_W-1:0];
			end
			w.kind   = KIND_VERDICT;
			w.placed = got;
			w.idx    = where[DSS_IDX_W-1:0];
			w.job    = j;
			w.total  = sum_profit;
			w.last   = 1'b1;
			due_words.push_back(w);
		end else begin
			nfill = $countones(map_taken);
			k = 0;
			for (s = 0; s < latest_dl; s++) begin
				if (map_taken[s]) begin
					k++;
					w.kind   = KIND_ENTRY;
					w.placed = 1'b1;
					w.idx    = s[DSS_IDX_W-1:0];
					w.job    = map_owner[s];
					w.total  = sum_profit;
					w.last   = (k == nfill);
					due_words.push_back(w);
				end
			end
			if (nfill == 0) begin
				w.kind   = KIND_ENTRY;
				w.placed = 1'b0;
				w.idx    = '0;
				w.job    = '0;
				w.total  = sum_profit;
				w.last   = 1'b1;
				due_words.push_back(w);
			end
			map_taken  = '0;
			sum_profit = '0;
			latest_dl  = 0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_taken  = '0;
			sum_profit = '0;
			latest_dl  = 0;
			due_words.delete();
		end else begin
			// results first: none can stem from a word accepted at this same edge
			if (out_valid && !out_stall) begin
				if (due_words.size() == 0) begin
					report_mismatch("result word with nothing due");
				end else begin
					want = due_words.pop_front();
					check_field("kind", 32'(kind), 32'(want.kind));
					check_field("placed", 32'(placed), 32'(want.placed));
					check_field("slot_index", 32'(slot_index), 32'(want.idx));
					check_field("slot_job", 32'(slot_job), 32'(want.job));
					check_field("total_profit", 32'(total_profit), 32'(want.total));
					check_field("last", 32'(last), 32'(want.last));
				end
			end
			if (in_valid && !in_stall)
				place_or_dump(op, job_id, profit, deadline);
		end
		pending = due_words.size();
	end

endmodule

// ----- bench/tb_top.sv -----
// Testbench top for the deadline slot scheduler: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
	import dss_pkg::*;

	localparam int IDLE_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic                    op;
	logic [DSS_JOB_W-1:0]    job_id;
	logic [DSS_PROFIT_W-1:0] profit;
	logic [DSS_DL_W-1:0]     deadline;
	logic                    out_valid;
	logic                    out_stall;
	logic                    kind;
	logic                    placed;
	logic [DSS_IDX_W-1:0]    slot_index;
	logic [DSS_JOB_W-1:0]    slot_job;
	logic [DSS_SUM_W-1:0]    total_profit;
	logic                    last;

	int errors;
	int pending;
	int words_sent;
	int idle_cycles;
	bit quiet;
	bit gaps_on;
	bit hold_req;

	deadline_slot_scheduler_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.job_id       (job_id),
		.profit       (profit),
		.deadline     (deadline),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.placed       (placed),
		.slot_index   (slot_index),
		.slot_job     (slot_job),
		.total_profit (total_profit),
		.last         (last)
	);

	dss_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.job_id       (job_id),
		.profit       (profit),
		.deadline     (deadline),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.placed       (placed),
		.slot_index   (slot_index),
		.slot_job     (slot_job),
		.total_profit (total_profit),
		.last         (last),
		.errors       (errors),
		.pending      (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// end the run when neither channel moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	function automatic logic [DSS_DL_W-1:0] pick_deadline();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return 7'd64;
			2, 3:    return DSS_DL_W'($urandom_range(0, 64));
			default: return DSS_DL_W'($urandom_range(1, 8));
		endcase
	endfunction

	// offer one word and hold it until taken; valid stays high for the caller
	task automatic send_word(input logic o, input logic [DSS_JOB_W-1:0] j,
			input logic [DSS_PROFIT_W-1:0] p, input logic [DSS_DL_W-1:0] d);
		if (gaps_on && !quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= o;
		job_id   <= j;
		profit   <= p;
		deadline <= d;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		words_sent++;
	endtask

	// stop offering and wait for every owed result
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	// a run of jobs in falling profit order, closed by a readout
	task automatic job_batch(input int n, input bit full_map);
		logic [DSS_PROFIT_W-1:0] p;
		int i;
		p = full_map ? '1 : DSS_PROFIT_W'($urandom_range(0, 24'hFFFFFF));
		for (i = 0; i < n; i++) begin
			send_word(OP_SCHED, DSS_JOB_W'($urandom), p,
				full_map ? 7'd64 : pick_deadline());
			p = full_map ? p - DSS_PROFIT_W'($urandom_range(0, 3))
				: DSS_PROFIT_W'($urandom_range(0, p));
		end
		send_word(OP_READ, DSS_JOB_W'($urandom), DSS_PROFIT_W'($urandom),
			DSS_DL_W'($urandom_range(0, 64)));
	endtask

	initial begin
		bit did_fill;
		bit did_hold;
		bit did_pause;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		op          = OP_SCHED;
		job_id      = '0;
		profit      = '0;
		deadline    = '0;
		out_stall   = 1'b0;
		idle_cycles = 0;
		words_sent  = 0;
		quiet       = 1'b0;
		gaps_on     = 1'b1;
		hold_req    = 1'b0;
		did_fill    = 1'b0;
		did_hold    = 1'b0;
		did_pause   = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty map, zero deadline, full slots, top slot
		send_word(OP_READ, '0, '0, '0);
		send_word(OP_SCHED, 16'hFFFF, 24'hFFFFFF, 7'd64);
		send_word(OP_SCHED, 16'h0000, 24'h000000, 7'd0);
		send_word(OP_SCHED, 16'h0001, 24'h800000, 7'd1);
		send_word(OP_SCHED, 16'h0002, 24'h400000, 7'd1);
		send_word(OP_SCHED, 16'h0003, 24'h200000, 7'd2);
		send_word(OP_SCHED, 16'h0004, 24'h100000, 7'd2);
		send_word(OP_SCHED, 16'hAAAA, 24'h0AAAAA, 7'd63);
		send_word(OP_SCHED, 16'h5555, 24'h055555, 7'd64);
		send_word(OP_READ, '0, '0, '0);
		send_word(OP_READ, 16'hFFFF, 24'hFFFFFF, 7'd64);
		send_word(OP_SCHED, 16'h1234, 24'h000001, 7'd3);
		send_word(OP_READ, 16'hFFFF, 24'hFFFFFF, 7'd127);
		send_word(OP_SCHED, 16'h0000, 24'h000000, 7'd64);
		send_word(OP_SCHED, 16'h8001, 24'h000000, 7'd32);
		send_word(OP_READ, 16'h5A5A, 24'hA5A5A5, 7'd0);
		drain();

		while (words_sent < 230) begin
			quiet = (words_sent >= 190);
			if (!did_fill && words_sent >= 50) begin
				// fill every slot, then overflow with two more jobs
				job_batch(66, 1'b1);
				did_fill = 1'b1;
			end else if (!did_pause && words_sent >= 120) begin
				drain();
				did_pause = 1'b1;
			end else if (!did_hold && words_sent >= 140) begin
				// back up the output while jobs keep coming
				hold_req = 1'b1;
				gaps_on  = 1'b0;
				job_batch(24, 1'b0);
				gaps_on  = 1'b1;
				did_hold = 1'b1;
			end else if ($urandom_range(0, 9) == 0) begin
				send_word(1'($urandom_range(0, 1)), DSS_JOB_W'($urandom),
					DSS_PROFIT_W'($urandom), DSS_DL_W'($urandom_range(0, 64)));
			end else begin
				job_batch($urandom_range(1, 20), 1'b0);
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
